@@ rtl/lzd_pkg.sv @@
// shared types and constants for the lz byte stream decompressor
// no dependencies; imported by lz_byte_stream_decompressor and its testbench
`timescale 1ns / 1ps
`default_nettype none

package lzd_pkg;

	// default geometry
	localparam int WINDOW_DEPTH_DEF = 4096;
	localparam int COUNT_WIDTH_DEF  = 24;

	// fixed field widths
	localparam int SIZE_WIDTH = 24;
	localparam int OFS_WIDTH  = 12;

	// count extension constants
	localparam logic [7:0] NIBBLE_EXT = 8'd15;
	localparam logic [7:0] EXT_STEP   = 8'd255;

	// item operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [2:0] {
		PH_CONTROL   = 3'd0,
		PH_LIT_EXT   = 3'd1,
		PH_LIT_DATA  = 3'd2,
		PH_MATCH_EXT = 3'd3,
		PH_MATCH_OFS = 3'd4,
		PH_COPY      = 3'd5
	} phase_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] in_byte;
	} in_word_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       byte_taken;
		logic       need_byte;
		logic       done_res;
	} out_word_t;

endpackage

`default_nettype wire

@@ rtl/lz_byte_stream_decompressor.sv @@
// lz77 style byte stream decompressor with a history ring in one synchronous memory
// depends on lzd_pkg for word types, phase codes and constants
`timescale 1ns / 1ps
`default_nettype none

// each accepted word passes through stage 1 and then the output register to res_valid
// throughput: one word per cycle unless in_stall, bytes or ticks; single history port pair
//   (one read issued at accept, one write from the following stage, forwarded on collision)
// reset: control state clears at once; then a clearing pass writes zeros to all
//   WINDOW_DEPTH history entries, one per cycle, with in_stall held high throughout
// config writes are taken at any time, cfg_ready is always high
module lz_byte_stream_decompressor #(
	parameter int WINDOW_DEPTH = lzd_pkg::WINDOW_DEPTH_DEF,
	parameter int COUNT_WIDTH  = lzd_pkg::COUNT_WIDTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	// compressed word input
	input  wire                             in_valid,
	output logic                            in_stall,
	input  lzd_pkg::in_word_t               in_data,
	// result output
	output logic                            res_valid,
	input  wire                             res_stall,
	output lzd_pkg::out_word_t              res_data,
	// output_size register write
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [lzd_pkg::SIZE_WIDTH-1:0]   cfg_data
);
	import lzd_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);

	// history ring
	logic [7:0]             hist_mem [WINDOW_DEPTH];
	logic [7:0]             rd_data_q;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [7:0]             mem_wdata;

	// clearing pass
	logic                   clr_busy_q;
	logic [AW-1:0]          clr_addr_q;

	// config
	logic [SIZE_WIDTH-1:0]  output_size_q;

	// parse state
	phase_t                 phase_q, phase_n;
	logic [COUNT_WIDTH-1:0] rem_q, rem_n;
	logic [3:0]             nibble_q, nibble_n;
	logic [AW-1:0]          wp_q, wp_n;
	logic [AW-1:0]          copy_q, copy_n;
	logic [SIZE_WIDTH-1:0]  bp_q, bp_n;

	// stage 1
	logic                   s1_vld_s1;
	out_word_t              s1_res_s1;
	logic                   s1_use_mem_s1;
	logic [7:0]             s1_byte_s1;
	logic [AW-1:0]          s1_waddr_s1;
	logic                   s1_move;
	logic [7:0]             s1_byte;
	out_word_t              s1_word;

	// output register
	logic                   res_vld_q;
	out_word_t              res_q;

	// per-word decode
	logic                   in_acc;
	logic                   active;
	logic                   taken;
	logic                   emit;
	logic                   lit_emit;
	logic                   rd_en;
	logic                   fwd_hit;
	logic [7:0]             b;
	logic                   done_after;

	// count accumulate helpers
	logic [7:0]             add_val;
	logic [COUNT_WIDTH:0]   add_sum;
	logic [COUNT_WIDTH-1:0] rem_added;
	logic [COUNT_WIDTH-1:0] rem_pre;
	logic [COUNT_WIDTH-1:0] rem_dec;
	logic [AW-1:0]          ofs_ext;

	assign b         = in_data.in_byte;
	assign cfg_ready = 1'b1;

	// s1 moves into the output register when that is empty or being taken
	assign s1_move  = !res_vld_q || !res_stall;
	assign in_stall = clr_busy_q || (s1_vld_s1 && !s1_move);
	assign in_acc   = in_valid && !in_stall;

	assign res_valid = res_vld_q;
	assign res_data  = res_q;

	// ---------------------------------------------------------------------
	// output decode of the accepted word
	// ---------------------------------------------------------------------
	always_comb begin
		active   = bp_q < output_size_q;
		taken    = 1'b0;
		emit     = 1'b0;
		lit_emit = 1'b0;
		rd_en    = 1'b0;
		if (in_acc && active) begin
			if (in_data.operation == OP_TICK) begin
				if (phase_q == PH_COPY) begin
					emit  = 1'b1;
					rd_en = 1'b1;
				end
			end else if (phase_q != PH_COPY) begin
				taken = 1'b1;
				if (phase_q == PH_LIT_DATA) begin
					emit     = 1'b1;
					lit_emit = 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// next parse state
	// ---------------------------------------------------------------------
	always_comb begin
		add_val   = (b == 8'd0) ? EXT_STEP : b;
		add_sum   = {1'b0, rem_q} + (COUNT_WIDTH+1)'(add_val);
		rem_added = add_sum[COUNT_WIDTH] ? '1 : add_sum[COUNT_WIDTH-1:0];
		ofs_ext   = AW'({b, nibble_q});

		phase_n  = phase_q;
		rem_pre  = rem_q;
		nibble_n = nibble_q;
		copy_n   = copy_q;

		if (taken) begin
			case (phase_q)
				PH_LIT_EXT: begin
					rem_pre = rem_added;
					if (b != 8'd0)
						phase_n = PH_LIT_DATA;
				end
				PH_LIT_DATA: begin
				end
				PH_MATCH_EXT: begin
					rem_pre = rem_added;
					if (b != 8'd0)
						phase_n = PH_MATCH_OFS;
				end
				PH_MATCH_OFS: begin
					// offset wraps modulo the window
					if (wp_q >= ofs_ext)
						copy_n = wp_q - ofs_ext;
					else
						copy_n = AW'(({1'b0, wp_q} + (AW+1)'(WINDOW_DEPTH))
							- {1'b0, ofs_ext});
					phase_n = PH_COPY;
				end
				default: begin
					// control byte
					case (b) inside
						[8'd16:8'd255]: begin
							nibble_n = b[7:4];
							if (b[3:0] == 4'd0) begin
								rem_pre = COUNT_WIDTH'(NIBBLE_EXT);
								phase_n = PH_MATCH_EXT;
							end else begin
								rem_pre = COUNT_WIDTH'(b[3:0]);
								phase_n = PH_MATCH_OFS;
							end
						end
						8'd0: begin
							rem_pre = COUNT_WIDTH'(NIBBLE_EXT);
							phase_n = PH_LIT_EXT;
						end
						default: begin
							rem_pre = COUNT_WIDTH'(b);
							phase_n = PH_LIT_DATA;
						end
					endcase
				end
			endcase
		end

		if (rd_en)
			copy_n = (copy_q == AW'(WINDOW_DEPTH-1)) ? '0 : copy_q + 1'b1;

		// emitting a byte consumes one count and advances the ring
		rem_dec = (rem_pre != '0) ? rem_pre - 1'b1 : rem_pre;
		rem_n   = rem_pre;
		wp_n    = wp_q;
		bp_n    = bp_q;
		if (emit) begin
			rem_n = rem_dec;
			wp_n  = (wp_q == AW'(WINDOW_DEPTH-1)) ? '0 : wp_q + 1'b1;
			bp_n  = bp_q + 1'b1;
			if (rem_dec == '0)
				phase_n = PH_CONTROL;
		end

		done_after = bp_n >= output_size_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_CONTROL;
			rem_q         <= '0;
			nibble_q      <= '0;
			wp_q          <= '0;
			copy_q        <= '0;
			bp_q          <= '0;
			output_size_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				output_size_q <= cfg_data;
			if (in_acc) begin
				phase_q  <= phase_n;
				rem_q    <= rem_n;
				nibble_q <= nibble_n;
				wp_q     <= wp_n;
				copy_q   <= copy_n;
				bp_q     <= bp_n;
			end
		end
	end

	// ---------------------------------------------------------------------
	// clearing pass after reset
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(WINDOW_DEPTH-1))
				clr_busy_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------
	// history memory: write from clear or stage 1, read at accept
	// ---------------------------------------------------------------------
	assign s1_byte   = s1_use_mem_s1 ? rd_data_q : s1_byte_s1;
	assign mem_we    = clr_busy_q || (s1_vld_s1 && s1_res_s1.out_valid && s1_move);
	assign mem_waddr = clr_busy_q ? clr_addr_q : s1_waddr_s1;
	assign mem_wdata = clr_busy_q ? 8'd0 : s1_byte;

	// a copy reading the entry written at this same edge takes the byte directly
	assign fwd_hit = mem_we && !clr_busy_q && (mem_waddr == copy_q);

	always_ff @(posedge clk) begin
		if (mem_we)
			hist_mem[mem_waddr] <= mem_wdata;
		if (rd_en)
			rd_data_q <= hist_mem[copy_q];
	end

	// ---------------------------------------------------------------------
	// stage 1 and output register
	// ---------------------------------------------------------------------
	// stage 1 word with its byte filled in from memory or the stored value
	always_comb begin
		s1_word          = s1_res_s1;
		s1_word.out_byte = s1_res_s1.out_valid ? s1_byte : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (in_acc)
				s1_vld_s1 <= 1'b1;
			else if (s1_move)
				s1_vld_s1 <= 1'b0;
			if (s1_move)
				res_vld_q <= s1_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_res_s1.out_valid  <= emit;
			s1_res_s1.out_byte   <= 8'd0;
			s1_res_s1.byte_taken <= taken;
			s1_res_s1.need_byte  <= !done_after && (phase_n != PH_COPY);
			s1_res_s1.done_res   <= done_after;
			s1_waddr_s1          <= wp_q;
			s1_use_mem_s1        <= rd_en && !fwd_hit;
			s1_byte_s1           <= lit_emit ? b : s1_byte;
		end
		if (s1_move && s1_vld_s1)
			res_q <= s1_word;
	end

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy_q |=> !clr_busy_q)
		else $error("clearing pass restarted");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COPY || phase_q == PH_LIT_DATA) |-> (rem_q != '0))
		else $error("copy or literal phase with zero count");

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s1_vld_s1)
		else $error("data write pending during clearing pass");

	a_done_no_need: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |-> !(res_q.done_res && res_q.need_byte))
		else $error("result asks for a byte after done");

	a_fwd_select: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && rd_en && fwd_hit) |=> !s1_use_mem_s1)
		else $error("colliding copy read not forwarded");

endmodule

`default_nettype wire

@@ tb/sv/lz_byte_stream_decompressor_tb.sv @@
// self-checking testbench for lz_byte_stream_decompressor: byte and tick words in, decoded words out
// depends on lzd_pkg for word types, phase codes and constants, and on the rtl top level
`timescale 1ns / 1ps

module lz_byte_stream_decompressor_tb;
	import lzd_pkg::*;

	localparam int RING_DEPTH  = WINDOW_DEPTH_DEF;
	localparam int CNT_W       = COUNT_WIDTH_DEF;
	// quiet cycles allowed before giving up; covers the ring clearing pass after reset
	localparam int QUIET_LIMIT = 20000;
	localparam int LONG_HOLD   = 64;
	localparam int TAIL_CYCLES = 8;
	localparam logic [SIZE_WIDTH-1:0] SIZE_MAX = '1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_word_t              in_data   = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	out_word_t             res_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [SIZE_WIDTH-1:0] cfg_data  = '0;

	// decoder model state, updated once per accepted input word
	logic [7:0]            ring_model [RING_DEPTH];
	logic [OFS_WIDTH-1:0]  wr_ptr     = '0;
	logic [OFS_WIDTH-1:0]  rd_ptr     = '0;
	logic [SIZE_WIDTH-1:0] bytes_out  = '0;
	logic [SIZE_WIDTH-1:0] size_cfg   = '0;
	logic [CNT_W-1:0]      count_left = '0;
	logic [3:0]            ofs_nibble = '0;
	phase_t                parse_st   = PH_CONTROL;

	out_word_t expected_out[$];

	// run bookkeeping and knobs shared by the test tasks and the side processes
	int unsigned words_in     = 0;
	int unsigned items_sent   = 0;
	int unsigned results_seen = 0;
	int unsigned size_writes  = 0;
	int unsigned holds_done   = 0;
	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;
	bit          src_gaps     = 1'b1;
	bit          sink_gaps    = 1'b1;
	bit          noise_on     = 1'b0;
	bit          hold_req     = 1'b0;

	always #2 clk = ~clk;

	lz_byte_stream_decompressor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// count accumulator clamps at all ones instead of wrapping
	function automatic void add_count(input logic [7:0] v);
		logic [CNT_W:0] sum;
		sum = {1'b0, count_left} + (CNT_W+1)'(v);
		if (sum[CNT_W]) begin
			count_left = '1;
		end else begin
			count_left = sum[CNT_W-1:0];
		end
	endfunction

	// every produced byte goes into the ring and counts down the current run
	function automatic void emit_byte(input logic [7:0] b);
		ring_model[wr_ptr] = b;
		wr_ptr    = wr_ptr + 1'b1;
		bytes_out = bytes_out + 1'b1;
		if (count_left != '0) begin
			count_left = count_left - 1'b1;
		end
		if (count_left == '0) begin
			parse_st = PH_CONTROL;
		end
	endfunction

	function automatic out_word_t decode_step(input in_word_t w);
		out_word_t r;
		r = '0;
		// once output_size is reached every word is ignored
		if (bytes_out < size_cfg) begin
			if (w.operation == OP_TICK) begin
				// ticks only matter while copying a match
				if (parse_st == PH_COPY) begin
					r.out_valid = 1'b1;
					r.out_byte  = ring_model[rd_ptr];
					rd_ptr      = rd_ptr + 1'b1;
					emit_byte(r.out_byte);
				end
			end else if (parse_st != PH_COPY) begin
				r.byte_taken = 1'b1;
				case (parse_st)
					PH_LIT_EXT, PH_MATCH_EXT: begin
						// zero adds a full step and keeps extending, anything else ends it
						if (w.in_byte == 8'd0) begin
							add_count(EXT_STEP);
						end else begin
							add_count(w.in_byte);
							if (parse_st == PH_LIT_EXT) begin
								parse_st = PH_LIT_DATA;
							end else begin
								parse_st = PH_MATCH_OFS;
							end
						end
					end
					PH_LIT_DATA: begin
						r.out_valid = 1'b1;
						r.out_byte  = w.in_byte;
						emit_byte(w.in_byte);
					end
					PH_MATCH_OFS: begin
						// offset is the byte above the control nibble, wrapping around the ring
						rd_ptr   = wr_ptr - {w.in_byte, ofs_nibble};
						parse_st = PH_COPY;
					end
					default: begin
						if (w.in_byte > NIBBLE_EXT) begin
							ofs_nibble = w.in_byte[7:4];
							if (w.in_byte[3:0] == 4'd0) begin
								count_left = CNT_W'(NIBBLE_EXT);
								parse_st   = PH_MATCH_EXT;
							end else begin
								count_left = CNT_W'(w.in_byte[3:0]);
								parse_st   = PH_MATCH_OFS;
							end
						end else if (w.in_byte == 8'd0) begin
							count_left = CNT_W'(NIBBLE_EXT);
							parse_st   = PH_LIT_EXT;
						end else begin
							count_left = CNT_W'(w.in_byte);
							parse_st   = PH_LIT_DATA;
						end
					end
				endcase
			end
		end
		r.done_res  = (bytes_out >= size_cfg);
		r.need_byte = !r.done_res && (parse_st != PH_COPY);
		return r;
	endfunction

	// prediction at the edge where the block takes a word
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_out.push_back(decode_step(in_data));
			words_in++;
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// result checking against the oldest prediction
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (expected_out.size() == 0) begin
				$error("result word with no prediction pending: %h", res_data);
				mismatches++;
			end else begin
				want = expected_out.pop_front();
				check_field("out_valid", 8'(want.out_valid), 8'(res_data.out_valid));
				check_field("out_byte", want.out_byte, res_data.out_byte);
				check_field("byte_taken", 8'(want.byte_taken), 8'(res_data.byte_taken));
				check_field("need_byte", 8'(want.need_byte), 8'(res_data.need_byte));
				check_field("done_res", 8'(want.done_res), 8'(res_data.done_res));
			end
		end
	end

	// output side: random stall bursts, or one long hold when a test asks for it
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				res_stall <= 1'b0;
				holds_done++;
			end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("lz_byte_stream_decompressor regression: fail");
			$finish;
		end
	end

	// offer one word, with an optional gap first, and hold it until taken
	task automatic send_word(input logic op, input logic [7:0] b);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {op, b};
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// stop offering and wait until every predicted word has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_out.size() != 0) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_WIDTH-1:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_cfg = v;
		size_writes++;
	endtask

	// walk the parser back to a control byte, one word at a time, using the model state
	task automatic realign_parser();
		drain_results();
		while (bytes_out < size_cfg && parse_st != PH_CONTROL) begin
			case (parse_st)
				PH_COPY: send_word(OP_TICK, 8'($urandom_range(0, 255)));
				PH_LIT_EXT, PH_MATCH_EXT: send_word(OP_BYTE, 8'($urandom_range(1, 255)));
				default: send_word(OP_BYTE, 8'($urandom_range(0, 255)));
			endcase
			drain_results();
		end
	endtask

	// noise is a tick where a byte is wanted or a byte during a copy, both harmless
	task automatic send_parsed(input logic op, input logic [7:0] b);
		if (noise_on && $urandom_range(0, 15) == 0) begin
			send_word(!op, 8'($urandom_range(0, 255)));
		end
		send_word(op, b);
	endtask

	// count beyond the nibble: zeros worth 255 each, then a final nonzero byte
	task automatic send_count_ext(input int unsigned rest);
		while (rest > 255) begin
			send_parsed(OP_BYTE, 8'd0);
			rest -= 255;
		end
		send_parsed(OP_BYTE, 8'(rest));
	endtask

	task automatic send_literals(input int unsigned n);
		if (n <= 15) begin
			send_parsed(OP_BYTE, 8'(n));
		end else begin
			send_parsed(OP_BYTE, 8'd0);
			send_count_ext(n - 15);
		end
		repeat (n) send_parsed(OP_BYTE, 8'($urandom_range(0, 255)));
	endtask

	// ofs must have a nonzero low nibble, else the control byte reads as a literal run
	task automatic send_match(input int unsigned n, input logic [OFS_WIDTH-1:0] ofs);
		if (n <= 15) begin
			send_parsed(OP_BYTE, {ofs[3:0], n[3:0]});
		end else begin
			send_parsed(OP_BYTE, {ofs[3:0], 4'd0});
			send_count_ext(n - 15);
		end
		send_parsed(OP_BYTE, ofs[11:4]);
		repeat (n) send_parsed(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	function automatic int unsigned pick_run_length();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 18);
		end
		return $urandom_range(16, 300);
	endfunction

	// with output_size at zero the block is done from the start and ignores everything
	task automatic test_reset_window();
		write_size('0);
		send_word(OP_TICK, 8'hFF);
		send_word(OP_BYTE, 8'hFF);
		send_word(OP_BYTE, 8'h00);
	endtask

	task automatic test_directed();
		write_size(SIZE_WIDTH'(8));
		send_word(OP_BYTE, 8'h02);   // literal run of two
		send_word(OP_BYTE, 8'h00);
		send_word(OP_BYTE, 8'hFF);
		send_word(OP_TICK, 8'h00);   // tick while a byte is wanted
		send_word(OP_BYTE, 8'h12);   // match of two at offset one
		send_word(OP_BYTE, 8'h00);
		send_word(OP_BYTE, 8'h55);   // byte during a copy, not taken
		send_word(OP_TICK, 8'hFF);
		send_word(OP_TICK, 8'h00);
		send_word(OP_BYTE, 8'hF1);   // single-byte match at the farthest offset
		send_word(OP_BYTE, 8'hFF);
		send_word(OP_TICK, 8'h00);
		send_word(OP_BYTE, 8'h01);
		send_word(OP_BYTE, 8'h80);
		send_word(OP_BYTE, 8'h14);   // match of four, cut off by output_size after two
		send_word(OP_BYTE, 8'h00);
		send_word(OP_TICK, 8'h00);
		send_word(OP_TICK, 8'h00);
		send_word(OP_TICK, 8'h00);   // ignored, done
		send_word(OP_BYTE, 8'h77);   // ignored, done
		// raising output_size resumes the same match
		write_size(SIZE_WIDTH'(12));
		send_word(OP_TICK, 8'h00);
		send_word(OP_TICK, 8'h00);
		send_word(OP_BYTE, 8'h01);
		send_word(OP_BYTE, 8'h5A);
		send_word(OP_BYTE, 8'h01);
		send_word(OP_BYTE, 8'h33);   // lands exactly on output_size
	endtask

	task automatic test_count_extension();
		write_size(SIZE_MAX);
		realign_parser();
		send_literals(16);
		send_literals(271);
		send_literals(20);
		send_match(17, 12'h021);
		send_match(270, 12'h1F3);
		send_match(273, 12'hFFF);
	endtask

	task automatic test_random_streams();
		int unsigned mark;
		int unsigned pick;
		logic [OFS_WIDTH-1:0] ofs;
		for (int chunk = 0; chunk < 6; chunk++) begin
			src_gaps  = (chunk % 3) != 2;
			sink_gaps = (chunk % 4) != 3;
			noise_on  = (chunk % 2) == 0;
			write_size(SIZE_MAX);
			realign_parser();
			// some chunks stop short at a random output size
			if (chunk % 3 == 1) begin
				write_size(SIZE_WIDTH'(bytes_out + $urandom_range(1, 150)));
			end
			if (chunk == 2) begin
				hold_req = 1'b1;
			end
			mark = items_sent;
			while (items_sent - mark < 20) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					send_literals(pick_run_length());
				end else if (pick < 88) begin
					if ($urandom_range(0, 2) == 0) begin
						ofs = OFS_WIDTH'($urandom_range(1, RING_DEPTH - 1));
					end else begin
						ofs = OFS_WIDTH'($urandom_range(1, 80));
					end
					if (ofs[3:0] == 4'd0) begin
						ofs[3:0] = 4'($urandom_range(1, 15));
					end
					send_match(pick_run_length(), ofs);
				end else begin
					// broken sequence: raw words, then back to a control byte
					repeat ($urandom_range(1, 4)) begin
						send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
					end
					realign_parser();
				end
			end
		end
	endtask

	// closing stretch with no idle cycles on either side, ending on output_size
	task automatic test_no_idle_tail();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		noise_on  = 1'b0;
		write_size(SIZE_MAX);
		realign_parser();
		write_size(SIZE_WIDTH'(bytes_out + 40));
		send_literals(12);
		send_match(9, 12'h011);
		send_literals(3);
		send_match(15, 12'h0A5);
		send_literals(16);
	endtask

	initial begin
		foreach (ring_model[i]) begin
			ring_model[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_window();
		test_directed();
		test_count_extension();
		test_random_streams();
		test_no_idle_tail();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("summary: %0d words in, %0d results checked, %0d size writes, %0d long holds",
			words_in, results_seen, size_writes, holds_done);
		$display("summary: literal and match runs, multi-byte counts, stop and resume, busy tail");
		if (mismatches == 0) begin
			$display("lz_byte_stream_decompressor regression: pass");
		end else begin
			$display("lz_byte_stream_decompressor regression: fail");
		end
		$finish;
	end

endmodule
